// ===== design/token_bucket_shaper_defines.svh =====
// ----------------------------------------------------------------------------
// token_bucket_shaper_defines
// assertion macros used by the token bucket shaper checker
// ----------------------------------------------------------------------------
`ifndef TOKEN_BUCKET_SHAPER_DEFINES_SVH
`define TOKEN_BUCKET_SHAPER_DEFINES_SVH

// assertion checked only outside reset
`define TBS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion checked at every edge, reset included
`define TBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/tbs_pkg.sv =====
// ----------------------------------------------------------------------------
// tbs_pkg
// shared constants and types of the token bucket shaper
// ----------------------------------------------------------------------------
package tbs_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int TOKEN_W  = 8;
    localparam int STATUS_W = 3;
    localparam int QCOUNT_W = 5;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [TOKEN_W-1:0] BUCKET_DEPTH_RST = 8'd10;

    localparam logic [0:0] REG_BUCKET_DEPTH = 1'b0;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_PACKET = 1'b1;

    localparam logic [STATUS_W-1:0] ST_TOKEN_ADDED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TOKEN_DROP  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_QUEUED      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_BIG     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_QUEUE_FULL  = 3'd4;

    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

endpackage

// ===== design/tbs_in_if.sv =====
// ----------------------------------------------------------------------------
// tbs_in_if
// input channel: token ticks and packet arrivals
// ----------------------------------------------------------------------------
interface tbs_in_if;
    import tbs_pkg::*;

    logic               valid;
    logic               ready;
    logic               op;
    logic [TOKEN_W-1:0] tokens_needed;

    modport source (output valid, output op, output tokens_needed, input ready);
    modport sink   (input valid, input op, input tokens_needed, output ready);
endinterface

// ===== design/tbs_out_if.sv =====
// ----------------------------------------------------------------------------
// tbs_out_if
// result channel: one result per input transaction
// ----------------------------------------------------------------------------
interface tbs_out_if;
    import tbs_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                released;
    logic [TOKEN_W-1:0]  released_tokens;
    logic [TOKEN_W-1:0]  bucket_level;
    logic [QCOUNT_W-1:0] queue_count;

    modport source (output valid, output status, output released, output released_tokens,
                    output bucket_level, output queue_count, input ready);
    modport sink   (input valid, input status, input released, input released_tokens,
                    input bucket_level, input queue_count, output ready);
endinterface

// ===== design/tbs_ram.sv =====
// ----------------------------------------------------------------------------
// tbs_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module tbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

// ===== design/tbs_fifo.sv =====
// ----------------------------------------------------------------------------
// tbs_fifo
// waiting queue with the head entry always presented for the release check
// ----------------------------------------------------------------------------
module tbs_fifo #(
    parameter int QUEUE_DEPTH = tbs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  tbs_pkg::fifo_ctrl_t              ctrl,
    input  logic [tbs_pkg::TOKEN_W-1:0]      wr_data,
    output tbs_pkg::fifo_stat_t              stat,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] fill,
    output logic [tbs_pkg::TOKEN_W-1:0]      head_data
);
    import tbs_pkg::*;

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0]  LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FULL_FILL = FILL_W'(QUEUE_DEPTH);

    logic [PTR_W-1:0]   head_reg, head_next;
    logic [PTR_W-1:0]   tail_reg, tail_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               bypass_reg;
    logic [TOKEN_W-1:0] bypass_data_reg;
    logic [TOKEN_W-1:0] rd_data;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (ctrl.pop)
        begin
            head_next = (head_reg == LAST_SLOT) ? '0 : head_reg + 1'b1;
        end
        if (ctrl.push)
        begin
            tail_next = (tail_reg == LAST_SLOT) ? '0 : tail_reg + 1'b1;
        end
        case ({ctrl.push, ctrl.pop})
            2'b10:   fill_next = fill_reg + 1'b1;
            2'b01:   fill_next = fill_reg - 1'b1;
            default: fill_next = fill_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            tail_reg   <= '0;
            fill_reg   <= '0;
            bypass_reg <= 1'b0;
        end
        else
        begin
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            fill_reg   <= fill_next;
            bypass_reg <= ctrl.push && (tail_reg == head_next);
        end
    end

    // write into the slot that becomes the head is forwarded past the ram
    always_ff @(posedge clk)
    begin
        bypass_data_reg <= wr_data;
    end

    tbs_ram #(
        .WIDTH (TOKEN_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ctrl.push),
        .wr_addr (tail_reg),
        .wr_data (wr_data),
        .rd_addr (head_next),
        .rd_data (rd_data)
    );

    assign head_data  = bypass_reg ? bypass_data_reg : rd_data;
    assign fill       = fill_reg;
    assign stat.empty = (fill_reg == '0);
    assign stat.full  = (fill_reg == FULL_FILL);
endmodule

// ===== design/token_bucket_shaper.sv =====
// ----------------------------------------------------------------------------
// token_bucket_shaper
// token bucket shaper with a waiting queue of packets
// ----------------------------------------------------------------------------
// usage
//   in_ch takes one transaction per item: op 0 is a token tick, op 1 a packet
//   arrival with tokens_needed. out_ch gives exactly one result per item:
//   status, whether the head packet was released and its tokens, the bucket
//   level and the queue fill after the item.
//   an input transaction is taken into the input register and is decided
//   from there into the result register, which raises result valid. one
//   item is taken per cycle when the receiver keeps up; the rate rests on
//   the combinational loop through the bucket level and the queue
//   pointers, which decides each item in full.
//   bucket_depth is written over the apb port (byte address 0); it resets
//   to 10. the user writes it only while the block is idle; the block does
//   not enforce this. reset empties the bucket and the queue and drops any
//   item in flight; the queue storage needs no clearing.
//   when out_ch.ready is low the result holds, one more item waits in the
//   input register and in_ch.ready then falls.
// ----------------------------------------------------------------------------
module token_bucket_shaper #(
    parameter int QUEUE_DEPTH = tbs_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    tbs_in_if.sink                         in_ch,
    tbs_out_if.source                      out_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [tbs_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [tbs_pkg::APB_DATA_W-1:0] pwdata,
    output logic [tbs_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import tbs_pkg::*;

    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    logic [TOKEN_W-1:0]  depth_reg;
    logic [TOKEN_W-1:0]  token_reg, token_next;

    logic                in_valid_reg;
    logic                op_reg;
    logic [TOKEN_W-1:0]  need_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic                released_reg;
    logic [TOKEN_W-1:0]  rel_tokens_reg, rel_tokens_next;
    logic [TOKEN_W-1:0]  level_reg;
    logic [QCOUNT_W-1:0] qcount_reg, qcount_next;

    logic                advance;
    logic                apb_write;
    fifo_ctrl_t          fifo_ctrl;
    fifo_stat_t          fifo_stat;
    logic [FILL_W-1:0]   fill;
    logic [FILL_W-1:0]   fill_push;
    logic [FILL_W-1:0]   fill_after;
    logic [FILL_W+QCOUNT_W-1:0] fill_wide;
    logic [TOKEN_W-1:0]  head_data;
    logic [TOKEN_W-1:0]  head_need;
    logic [TOKEN_W-1:0]  token_mid;
    logic                push;
    logic                pop;

    // configuration
    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg <= BUCKET_DEPTH_RST;
        end
        else if (apb_write && (paddr[2:2] == REG_BUCKET_DEPTH))
        begin
            depth_reg <= pwdata[TOKEN_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2:2] == REG_BUCKET_DEPTH)
        begin
            prdata[TOKEN_W-1:0] = depth_reg;
        end
    end

    // handshake
    assign advance     = in_valid_reg && (!out_valid_reg || out_ch.ready);
    assign in_ch.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            in_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            op_reg   <= in_ch.op;
            need_reg <= in_ch.tokens_needed;
        end
    end

    // item decision
    always_comb
    begin
        token_mid   = token_reg;
        push        = 1'b0;
        status_next = ST_TOKEN_ADDED;
        case (op_reg)
            OP_TICK:
            begin
                if (token_reg >= depth_reg)
                begin
                    status_next = ST_TOKEN_DROP;
                end
                else
                begin
                    token_mid   = token_reg + 1'b1;
                    status_next = ST_TOKEN_ADDED;
                end
            end
            OP_PACKET:
            begin
                if (need_reg > depth_reg)
                begin
                    status_next = ST_TOO_BIG;
                end
                else if (fifo_stat.full)
                begin
                    status_next = ST_QUEUE_FULL;
                end
                else
                begin
                    push        = 1'b1;
                    status_next = ST_QUEUED;
                end
            end
            default:
            begin
                status_next = ST_TOKEN_ADDED;
            end
        endcase

        fill_push       = fill + FILL_W'(push);
        head_need       = fifo_stat.empty ? need_reg : head_data;
        pop             = (fill_push != '0) && (head_need <= token_mid);
        token_next      = pop ? token_mid - head_need : token_mid;
        rel_tokens_next = pop ? head_need : '0;
        fill_after      = fill_push - FILL_W'(pop);
        fill_wide       = {{QCOUNT_W{1'b0}}, fill_after};
        qcount_next     = fill_wide[QCOUNT_W-1:0];
    end

    assign fifo_ctrl.push = advance && push;
    assign fifo_ctrl.pop  = advance && pop;

    tbs_fifo #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (fifo_ctrl),
        .wr_data   (need_reg),
        .stat      (fifo_stat),
        .fill      (fill),
        .head_data (head_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                token_reg <= token_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg     <= status_next;
            released_reg   <= pop;
            rel_tokens_reg <= rel_tokens_next;
            level_reg      <= token_next;
            qcount_reg     <= qcount_next;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.status          = status_reg;
    assign out_ch.released        = released_reg;
    assign out_ch.released_tokens = rel_tokens_reg;
    assign out_ch.bucket_level    = level_reg;
    assign out_ch.queue_count     = qcount_reg;
endmodule

// ===== design/tbs_checker.sv =====
// ----------------------------------------------------------------------------
// tbs_checker
// port-level checks of the token bucket shaper
// ----------------------------------------------------------------------------
`include "token_bucket_shaper_defines.svh"

module tbs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          released,
    input logic [tbs_pkg::TOKEN_W-1:0]   released_tokens,
    input logic [tbs_pkg::STATUS_W-1:0]  status
);
    import tbs_pkg::*;

    `TBS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(status), "result dropped while stalled")
    `TBS_ASSERT(a_rel_zero, clk, rst_n, out_valid && !released |-> released_tokens == '0, "released tokens without a release")
    `TBS_ASSERT(a_ready_free, clk, rst_n, !out_valid |-> in_ready, "input stalled with result side empty")
    `TBS_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |-> !out_valid, "result valid during reset")
endmodule

bind token_bucket_shaper tbs_checker u_tbs_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ready        (in_ch.ready),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .released        (out_ch.released),
    .released_tokens (out_ch.released_tokens),
    .status          (out_ch.status)
);
